[rtl/core/vgm_command_translator_assert.svh]
// Assertion helpers shared by the RTL. clk and rst_n come from the using scope.
`ifndef VGM_COMMAND_TRANSLATOR_ASSERT_SVH
`define VGM_COMMAND_TRANSLATOR_ASSERT_SVH

// same-cycle implication
`define VCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VCT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/vct_pkg.sv]
`default_nettype none

package vct_pkg;

    localparam int ByteW     = 8;
    localparam int PosW      = 32;
    localparam int CfgIdxW   = 1;
    localparam int GrpMax    = 5;
    localparam int GrpCntW   = $clog2(GrpMax + 1);
    localparam int GrpIdxW   = $clog2(GrpMax);
    localparam int RegMapDepth = 48;
    localparam int RegMapIdxW  = $clog2(RegMapDepth);

    localparam logic [ByteW-1:0] CmdWrite  = 8'hB3;
    localparam logic [ByteW-1:0] CmdWait   = 8'h62;
    localparam logic [ByteW-1:0] CmdEnd    = 8'h66;
    localparam logic [ByteW-1:0] EndMarker = 8'hFF;
    localparam logic [ByteW-1:0] WaitByte  = 8'h00;

    localparam logic [PosW-1:0] DataStartRst = 32'h0000_0040;
    localparam logic [PosW-1:0] OutPosRst    = 32'd4;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DATA_START  = 1'b0,
        CFG_LOOP_OFFSET = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_REG     = 2'd1,
        ST_UNKNOWN_CMD = 2'd2,
        ST_NO_LOOP     = 2'd3
    } status_t;

    // one burst of result bytes caused by a single input byte
    typedef struct packed {
        logic [GrpMax-1:0][ByteW-1:0] bytes;
        logic [GrpCntW-1:0]           count;
        status_t                      status;
    } grp_t;

    // register remap; zero marks an unmapped register
    localparam logic [ByteW-1:0] RegMap [RegMapDepth] = '{
        8'h60, 8'h62, 8'h63, 8'h64, 8'h65, 8'h00, 8'h68, 8'h69,
        8'h6C, 8'h6D, 8'h70, 8'h72, 8'h73, 8'h74, 8'h75, 8'h00,
        8'h78, 8'h79, 8'h7C, 8'h7D, 8'h80, 8'h81, 8'h84, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
        8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F
    };

endpackage

`default_nettype wire

[rtl/core/vct_cmd_if.sv]
`default_nettype none

interface vct_cmd_if import vct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/vct_res_if.sv]
`default_nettype none

interface vct_res_if import vct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] out_byte;
    logic             last;
    logic [1:0]       status;

    modport source (output valid, output out_byte, output last, output status, input ready);
    modport sink   (input valid, input out_byte, input last, input status, output ready);
endinterface

`default_nettype wire

[rtl/core/vct_parser.sv]
`default_nettype none
`include "vgm_command_translator_assert.svh"

module vct_parser import vct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [PosW-1:0]    cfg_data,
    vct_cmd_if.sink                 cmd,
    input  wire logic               space,
    output logic                    push,
    output grp_t                    grp
);

    typedef enum logic [1:0] {
        PH_CMD = 2'd0,
        PH_REG = 2'd1,
        PH_VAL = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [PosW-1:0]  loop_offset_reg;
    logic [PosW-1:0]  in_pos_reg;
    logic [PosW-1:0]  out_pos_reg, out_pos_next;
    logic [PosW-1:0]  loop_mark_reg, loop_mark_next;
    logic [ByteW-1:0] held_reg, held_next;
    logic             halted_reg, halted_next;

    logic             work;
    logic             loop_hit;
    logic [PosW-1:0]  mark_now;
    logic [ByteW-1:0] mapped;

    // halted input is swallowed, so ready only waits on the result register otherwise
    assign cmd.ready = halted_reg || space;
    assign work      = cmd.valid && cmd.ready && !halted_reg;

    assign loop_hit = (loop_offset_reg != '0) && (in_pos_reg == loop_offset_reg);
    assign mark_now = loop_hit ? out_pos_reg : loop_mark_reg;
    assign mapped   = (held_reg < ByteW'(RegMapDepth)) ? RegMap[held_reg[RegMapIdxW-1:0]]
                                                       : '0;

    always_comb
    begin
        phase_next     = phase_reg;
        out_pos_next   = out_pos_reg;
        loop_mark_next = loop_mark_reg;
        held_next      = held_reg;
        halted_next    = halted_reg;
        push           = 1'b0;
        grp            = '0;
        grp.status     = ST_OK;
        if (work)
        begin
            unique case (phase_reg)
                PH_REG:
                begin
                    held_next  = cmd.in_byte;
                    phase_next = PH_VAL;
                end
                PH_VAL:
                begin
                    phase_next = PH_CMD;
                    push       = 1'b1;
                    if (mapped == '0)
                    begin
                        halted_next = 1'b1;
                        grp.count   = GrpCntW'(1);
                        grp.status  = ST_BAD_REG;
                    end
                    else
                    begin
                        grp.bytes[0] = mapped;
                        grp.bytes[1] = cmd.in_byte;
                        grp.count    = GrpCntW'(2);
                        out_pos_next = out_pos_reg + PosW'(2);
                    end
                end
                default:
                begin
                    // command phase; the unused code lands here too
                    phase_next     = PH_CMD;
                    loop_mark_next = mark_now;
                    unique case (cmd.in_byte)
                        CmdWrite:
                        begin
                            phase_next = PH_REG;
                        end
                        CmdWait:
                        begin
                            push         = 1'b1;
                            grp.bytes[0] = WaitByte;
                            grp.count    = GrpCntW'(1);
                            out_pos_next = out_pos_reg + PosW'(1);
                        end
                        CmdEnd:
                        begin
                            push         = 1'b1;
                            halted_next  = 1'b1;
                            grp.bytes[0] = EndMarker;
                            grp.bytes[1] = mark_now[7:0];
                            grp.bytes[2] = mark_now[15:8];
                            grp.bytes[3] = mark_now[23:16];
                            grp.bytes[4] = mark_now[31:24];
                            grp.count    = GrpCntW'(GrpMax);
                            grp.status   = (loop_offset_reg != '0 && mark_now == '0)
                                           ? ST_NO_LOOP : ST_OK;
                            out_pos_next = out_pos_reg + PosW'(GrpMax);
                        end
                        default:
                        begin
                            push        = 1'b1;
                            halted_next = 1'b1;
                            grp.count   = GrpCntW'(1);
                            grp.status  = ST_UNKNOWN_CMD;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CMD;
            loop_offset_reg <= '0;
            in_pos_reg      <= DataStartRst;
            out_pos_reg     <= OutPosRst;
            loop_mark_reg   <= '0;
            held_reg        <= '0;
            halted_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_pos_reg   <= out_pos_next;
            loop_mark_reg <= loop_mark_next;
            held_reg      <= held_next;
            halted_reg    <= halted_next;
            // data_start only matters as the reload value of the input position
            if (cfg_we && cfg_index == CFG_DATA_START)
            begin
                in_pos_reg <= cfg_data;
            end
            else if (work)
            begin
                in_pos_reg <= in_pos_reg + PosW'(1);
            end
            if (cfg_we && cfg_index == CFG_LOOP_OFFSET)
            begin
                loop_offset_reg <= cfg_data;
            end
        end
    end

    `VCT_ASSERT_NXT(a_halt_sticks, halted_reg, halted_reg, "halt released without reset")
    `VCT_ASSERT_IMP(a_error_single, push && grp.status == ST_BAD_REG,
                    grp.count == GrpCntW'(1), "bad register burst not single")
    `VCT_ASSERT_NXT(a_no_work_halted, halted_reg, $stable(out_pos_reg),
                    "output offset moved while halted")

endmodule

`default_nettype wire

[rtl/core/vct_emitter.sv]
`default_nettype none
`include "vgm_command_translator_assert.svh"

module vct_emitter import vct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire grp_t grp,
    output logic      space,
    vct_res_if.source res
);

    grp_t               grp_reg;
    logic               valid_reg;
    logic [GrpIdxW-1:0] idx_reg;
    logic               fire;
    logic               pop;

    assign res.valid    = valid_reg;
    assign res.out_byte = grp_reg.bytes[idx_reg];
    assign res.last     = (GrpCntW'(idx_reg) == grp_reg.count - GrpCntW'(1));
    assign res.status   = grp_reg.status;

    assign fire  = valid_reg && res.ready;
    assign pop   = fire && res.last;
    // a new burst may load on the cycle the old one hands over its final byte
    assign space = !valid_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + GrpIdxW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            grp_reg <= grp;
        end
    end

    `VCT_ASSERT_IMP(a_idx_in_burst, valid_reg, GrpCntW'(idx_reg) < grp_reg.count,
                    "byte index past burst")
    `VCT_ASSERT_IMP(a_push_has_room, push, space, "burst loaded over a pending one")
    `VCT_ASSERT_NXT(a_pop_clears, pop && !push, !valid_reg,
                    "result still valid after last byte")

endmodule

`default_nettype wire

[rtl/core/vgm_command_translator.sv]
// VGM command translator.
// cmd carries one stream byte per request (valid/ready); res carries the
// translated bytes with last on the final byte of each burst and a status.
// cfg_we/cfg_index/cfg_data write data_start (index 0, also reloads the input
// position) and loop_offset (index 1); write only while the block is idle.
// A request's first result byte is valid the cycle after it is accepted.
// Throughput: one request per cycle while the output register has room; a
// request that yields result bytes holds the output register until its last
// byte is taken. Unless the block is halted, every request, including 0xB3
// and register bytes that yield nothing, is accepted only while the output
// register is empty or in the cycle its last byte is taken. Reset clears the
// parse state, sets the positions to 0x40 and 4, and drops any pending
// result. While res is stalled the current byte holds and cmd.ready stays
// low unless the block is halted (then input is dropped). After an end
// command, bad register or unknown command the block halts until reset.
`default_nettype none

module vgm_command_translator import vct_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [PosW-1:0]    cfg_data,
    vct_cmd_if.sink                 cmd,
    vct_res_if.source               res
);

    logic push;
    logic space;
    grp_t grp;

    vct_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .space     (space),
        .push      (push),
        .grp       (grp)
    );

    vct_emitter u_emitter (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .grp   (grp),
        .space (space),
        .res   (res)
    );

endmodule

`default_nettype wire

[sim/vgm_command_translator_tb.sv]
`timescale 1ns / 1ps

module vgm_command_translator_tb;
    import vct_pkg::*;

    typedef enum logic [1:0] {
        STEP_CMD = 2'd0,
        STEP_REG = 2'd1,
        STEP_VAL = 2'd2
    } parse_step_t;

    // the one halting event of the run
    typedef enum logic [1:0] {
        END_LOOPED   = 2'd0,
        END_UNLOOPED = 2'd1,
        END_BAD_REG  = 2'd2,
        END_UNKNOWN  = 2'd3
    } ending_t;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             last;
        status_t          status;
    } out_rec_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [PosW-1:0] cfg_data = '0;

    vct_cmd_if cmd_bus ();
    vct_res_if res_bus ();

    vgm_command_translator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .res       (res_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // translator state as predicted
    logic [PosW-1:0] data_start_m;
    logic [PosW-1:0] loop_offset_m;
    parse_step_t     step_m;
    logic [PosW-1:0] in_pos_m;
    logic [PosW-1:0] out_pos_m;
    logic [PosW-1:0] loop_mark_m;
    logic [ByteW-1:0] held_reg_m;
    logic            halted_m;

    out_rec_t        expected_out[$];
    logic [ByteW-1:0] stream_q[$];
    int unsigned     pushed_count = 0;
    int unsigned     accepted_count = 0;
    int unsigned     err_count = 0;
    int              send_gap_pct = 0;
    int              res_stall_pct = 0;

    task automatic report_mismatch(input string msg);
        if (err_count < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void expect_out(input logic [ByteW-1:0] b, input logic lst,
                                       input status_t st);
        out_rec_t r;
        r.out_byte = b;
        r.last     = lst;
        r.status   = st;
        expected_out.push_back(r);
    endfunction

    task automatic translate_byte(input logic [ByteW-1:0] b);
        logic [PosW-1:0]  pos;
        logic [ByteW-1:0] mapped;
        status_t          st;
        if (halted_m)
            return;
        pos = in_pos_m;
        in_pos_m = pos + 1;
        case (step_m)
            STEP_REG:
            begin
                held_reg_m = b;
                step_m = STEP_VAL;
            end
            STEP_VAL:
            begin
                mapped = (held_reg_m < RegMapDepth) ? RegMap[held_reg_m[5:0]] : 8'h00;
                step_m = STEP_CMD;
                if (mapped == 8'h00)
                begin
                    halted_m = 1'b1;
                    expect_out(8'h00, 1'b1, ST_BAD_REG);
                end
                else
                begin
                    expect_out(mapped, 1'b0, ST_OK);
                    expect_out(b, 1'b1, ST_OK);
                    out_pos_m = out_pos_m + 2;
                end
            end
            default:
            begin
                step_m = STEP_CMD;
                if (loop_offset_m != 0 && pos == loop_offset_m)
                    loop_mark_m = out_pos_m;
                if (b == CmdWrite)
                    step_m = STEP_REG;
                else if (b == CmdWait)
                begin
                    expect_out(WaitByte, 1'b1, ST_OK);
                    out_pos_m = out_pos_m + 1;
                end
                else if (b == CmdEnd)
                begin
                    st = (loop_offset_m != 0 && loop_mark_m == 0) ? ST_NO_LOOP : ST_OK;
                    expect_out(EndMarker, 1'b0, st);
                    for (int k = 0; k < 4; k++)
                        expect_out(loop_mark_m[8*k +: 8], k == 3, st);
                    out_pos_m = out_pos_m + 5;
                    halted_m = 1'b1;
                end
                else
                begin
                    halted_m = 1'b1;
                    expect_out(8'h00, 1'b1, ST_UNKNOWN_CMD);
                end
            end
        endcase
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid   <= 1'b0;
            cmd_bus.in_byte <= '0;
        end
        else if (!cmd_bus.valid || cmd_bus.ready)
        begin
            if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                cmd_bus.valid   <= 1'b1;
                cmd_bus.in_byte <= stream_q.pop_front();
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
            res_bus.ready <= ($urandom_range(0, 99) >= res_stall_pct);
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        out_rec_t want;
        if (rst_n)
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                accepted_count++;
                translate_byte(cmd_bus.in_byte);
            end
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_out.size() == 0)
                    report_mismatch($sformatf("unexpected result byte %02h",
                                              res_bus.out_byte));
                else
                begin
                    want = expected_out.pop_front();
                    if (res_bus.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  res_bus.out_byte, want.out_byte));
                    if (res_bus.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b",
                                                  res_bus.last, want.last));
                    if (res_bus.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  res_bus.status, want.status));
                end
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [PosW-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DATA_START)
        begin
            data_start_m = val;
            in_pos_m     = val;
        end
        else
            loop_offset_m = val;
    endtask

    task automatic push_byte(input logic [ByteW-1:0] b);
        stream_q.push_back(b);
        pushed_count++;
    endtask

    task automatic push_write(input logic [ByteW-1:0] reg_b, input logic [ByteW-1:0] val);
        push_byte(CmdWrite);
        push_byte(reg_b);
        push_byte(val);
    endtask

    function automatic logic [ByteW-1:0] pick_good_reg();
        logic [ByteW-1:0] r;
        do
            r = ByteW'($urandom_range(0, RegMapDepth - 1));
        while (RegMap[r[5:0]] == 8'h00);
        return r;
    endfunction

    // well-formed writes and waits, some to the first and last mapped registers; values often look like command codes
    task automatic push_random(input int unsigned budget);
        int unsigned      start;
        int               roll;
        logic [ByteW-1:0] val;
        start = pushed_count;
        while (pushed_count - start < budget)
        begin
            roll = $urandom_range(0, 99);
            case ($urandom_range(0, 4))
                0: val = CmdWrite;
                1: val = CmdEnd;
                default: val = ByteW'($urandom_range(0, 255));
            endcase
            if (roll < 60)
                push_write(pick_good_reg(), val);
            else if (roll < 85)
                push_byte(CmdWait);
            else
                push_write($urandom_range(0, 1) ? 8'h00 : 8'h2F,
                           $urandom_range(0, 1) ? 8'h00 : 8'hFF);
        end
    endtask

    task automatic wait_until_idle();
        int guard;
        guard = 0;
        while ((accepted_count != pushed_count || expected_out.size() != 0) && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        if (guard >= 200000)
            report_mismatch("stream did not drain");
        // bytes that produce nothing may still be in flight
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        ending_t          ending;
        logic [PosW-1:0]  base;
        logic [ByteW-1:0] b;

        rst_n           = 1'b0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.in_byte = '0;
        res_bus.ready   = 1'b0;
        data_start_m    = DataStartRst;
        loop_offset_m   = '0;
        step_m          = STEP_CMD;
        in_pos_m        = DataStartRst;
        out_pos_m       = OutPosRst;
        loop_mark_m     = '0;
        held_reg_m      = '0;
        halted_m        = 1'b0;
        ending = ending_t'($urandom_range(0, 3));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // positions wrap through zero here
        write_reg(CFG_DATA_START, 32'hFFFF_FFFE);
        write_reg(CFG_LOOP_OFFSET, 32'h0);
        push_write(8'h00, 8'h00);
        push_write(8'h2F, 8'hFF);
        push_byte(CmdWait);
        push_write(8'h01, CmdWrite);
        push_write(8'h02, CmdEnd);
        push_write(8'h20, CmdWait);
        push_byte(CmdWait);
        push_write(8'h16, 8'h80);
        push_write(8'h15, 8'h7F);
        push_random(40);
        wait_until_idle();

        send_gap_pct = 52;
        write_reg(CFG_DATA_START, 32'h0);
        write_reg(CFG_LOOP_OFFSET, 32'hFFFF_FFFF);
        push_random(45);
        wait_until_idle();

        send_gap_pct  = 0;
        res_stall_pct = 52;
        base = $urandom;
        write_reg(CFG_DATA_START, base);
        write_reg(CFG_LOOP_OFFSET,
                  (ending == END_UNLOOPED) ? 32'h0 : base + $urandom_range(0, 20));
        push_random(45);
        wait_until_idle();

        send_gap_pct  = 15;
        res_stall_pct = 15;
        write_reg(CFG_DATA_START, DataStartRst);
        write_reg(CFG_LOOP_OFFSET, (ending == END_UNLOOPED) ? 32'hFFFF_FFFF
                                   : DataStartRst + $urandom_range(0, 20));
        push_random(40);
        case (ending)
            END_BAD_REG:
            begin
                if ($urandom_range(0, 1))
                    b = ByteW'($urandom_range(8'h30, 8'hFF));
                else
                    do
                        b = ByteW'($urandom_range(0, RegMapDepth - 1));
                    while (RegMap[b[5:0]] != 8'h00);
                push_write(b, ByteW'($urandom_range(0, 255)));
            end
            END_UNKNOWN:
            begin
                do
                    b = ByteW'($urandom_range(0, 255));
                while (b == CmdWrite || b == CmdWait || b == CmdEnd);
                push_byte(b);
            end
            default:
                push_byte(CmdEnd);
        endcase
        // halted: these must be dropped silently
        push_byte(CmdWait);
        push_write(8'h00, 8'h00);
        push_byte(CmdEnd);
        push_byte(ByteW'($urandom_range(0, 255)));
        wait_until_idle();

        send_gap_pct  = 0;
        res_stall_pct = 0;
        repeat (20) @(posedge clk);
        if (expected_out.size() != 0)
            report_mismatch($sformatf("%0d result bytes never arrived", expected_out.size()));
        if (accepted_count != pushed_count)
            report_mismatch($sformatf("%0d of %0d requests accepted",
                                      accepted_count, pushed_count));

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
